/* hdl/trs_pkg.sv */
package trs_pkg;

  localparam int WORD_W = 32;
  localparam int FRAC_W = 16;
  localparam int PROD_W = 2 * WORD_W;
  // Three exact products with a doubling never need more than this.
  localparam int ACC_W  = PROD_W + 3;
  localparam int N_ENT  = 12;
  localparam int N_LOC  = 9;
  localparam int RND_W  = ACC_W - FRAC_W + 1;

  // Quaternion component select codes
  localparam logic [1:0] Q_X = 2'd0;
  localparam logic [1:0] Q_Y = 2'd1;
  localparam logic [1:0] Q_Z = 2'd2;
  localparam logic [1:0] Q_W = 2'd3;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  typedef struct packed {
    word_t trans_x;
    word_t trans_y;
    word_t trans_z;
    word_t quat_x;
    word_t quat_y;
    word_t quat_z;
    word_t quat_w;
    word_t scale_x;
    word_t scale_y;
    word_t scale_z;
    logic  chain_start;
  } in_item_t;

  typedef struct packed {
    word_t e00;
    word_t e01;
    word_t e02;
    word_t e10;
    word_t e11;
    word_t e12;
    word_t e20;
    word_t e21;
    word_t e22;
    word_t e30;
    word_t e31;
    word_t e32;
  } out_item_t;

  // One multiply request to the shared unit, with how its product is summed.
  typedef struct packed {
    logic  mul_en;
    logic  dbl;
    logic  neg;
    logic  first;
    logic  diag;
    word_t a;
    word_t b;
  } mac_req_t;

  typedef struct packed {
    logic       idle;
    logic       issue;
    logic       rnd;
    logic       commit;
    logic       loc;
    logic [1:0] i;
    logic [1:0] j;
    logic [1:0] k;
  } seq_ctl_t;

  // Operand pattern of one rotation coefficient: diag +- 2ab +- 2cd
  typedef struct packed {
    logic       diag;
    logic [1:0] a;
    logic [1:0] b;
    logic       neg_a;
    logic [1:0] c;
    logic [1:0] d;
    logic       neg_c;
  } elem_sel_t;

  function automatic elem_sel_t elem_sel(input logic [3:0] e);
    elem_sel_t s;
    s = '0;
    case (e)
      4'd0: s = '{1'b1, Q_Y, Q_Y, 1'b1, Q_Z, Q_Z, 1'b1};
      4'd1: s = '{1'b0, Q_X, Q_Y, 1'b0, Q_Z, Q_W, 1'b0};
      4'd2: s = '{1'b0, Q_X, Q_Z, 1'b0, Q_Y, Q_W, 1'b1};
      4'd3: s = '{1'b0, Q_X, Q_Y, 1'b0, Q_Z, Q_W, 1'b1};
      4'd4: s = '{1'b1, Q_X, Q_X, 1'b1, Q_Z, Q_Z, 1'b1};
      4'd5: s = '{1'b0, Q_Y, Q_Z, 1'b0, Q_X, Q_W, 1'b0};
      4'd6: s = '{1'b0, Q_X, Q_Z, 1'b0, Q_Y, Q_W, 1'b0};
      4'd7: s = '{1'b0, Q_Y, Q_Z, 1'b0, Q_X, Q_W, 1'b1};
      4'd8: s = '{1'b1, Q_X, Q_X, 1'b1, Q_Y, Q_Y, 1'b1};
      default: s = '0;
    endcase
    return s;
  endfunction

  // Round half up from 2*FRAC_W fraction bits and saturate to a word.
  function automatic word_t rnd_word(input acc_t v);
    logic signed [ACC_W:0]    s;
    logic signed [RND_W-1:0]  q;
    logic signed [RND_W-1:0]  q_max;
    logic signed [RND_W-1:0]  q_min;
    word_t                    r;
    q_max = RND_W'({1'b0, {(WORD_W-1){1'b1}}});
    q_min = ~q_max;
    s = (ACC_W+1)'(v) + (ACC_W+1)'(1 << (FRAC_W-1));
    q = s[ACC_W:FRAC_W];
    if (q > q_max) begin
      r = {1'b0, {(WORD_W-1){1'b1}}};
    end else if (q < q_min) begin
      r = {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      r = q[WORD_W-1:0];
    end
    return r;
  endfunction

  function automatic word_t sat_add(input word_t a, input word_t b);
    logic signed [WORD_W:0] s;
    word_t                  r;
    s = (WORD_W+1)'(a) + (WORD_W+1)'(b);
    if (s[WORD_W] != s[WORD_W-1]) begin
      r = s[WORD_W] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
    end else begin
      r = s[WORD_W-1:0];
    end
    return r;
  endfunction

endpackage

/* hdl/trs_node_world_transform_core.sv */
// Channel | Ports                          | Transaction
// --------+--------------------------------+-------------------------------------
// input   | in_valid, in_ready, in_data    | one node: translation, quat, scale
// output  | out_valid, out_ready, out_data | twelve accumulated matrix entries
//
// One 32x32 multiplier with a product register and an accumulator forms every product sum.
// A chain-start node steps through 9 local coefficients (ISSUE ab and cd, WAIT, RND, ISSUE
// scale, WAIT, RND), then DONE; an ancestor does 12 more entries (ISSUE x3, WAIT, RND) first.
// Synchronous active-low reset clears the accumulated matrix to zero.
// in_ready is high only while idle: no node is taken until the last one commits. A finished
// node holds in DONE while out_valid waits; after commit the next node may be taken.
module trs_node_world_transform_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  trs_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output trs_pkg::out_item_t out_data
);
  import trs_pkg::*;

  seq_ctl_t   ctl;
  mac_req_t   req;
  acc_t       acc;
  logic       mac_pend;
  logic       start;
  logic       slot_free;

  in_item_t   item_r;
  word_t      coef_r;
  word_t      l_r     [N_LOC];
  word_t      t_r     [N_ENT];
  word_t      accum_r [N_ENT];
  logic       out_valid_r;

  logic [3:0] e_idx;
  logic [3:0] a_idx;
  logic [3:0] b_idx;
  elem_sel_t  sel;
  word_t      scale_sel;
  word_t      trans_sel;
  word_t      rnd_val;

  function automatic word_t quat_pick(input in_item_t it, input logic [1:0] c);
    word_t r;
    case (c)
      Q_X:     r = it.quat_x;
      Q_Y:     r = it.quat_y;
      Q_Z:     r = it.quat_z;
      Q_W:     r = it.quat_w;
      default: r = it.quat_w;
    endcase
    return r;
  endfunction

  assign start     = in_valid && in_ready;
  assign in_ready  = ctl.idle;
  assign slot_free = !out_valid_r || out_ready;

  trs_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .chain_start (in_data.chain_start),
    .slot_free   (slot_free),
    .ctl         (ctl)
  );

  trs_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .acc   (acc),
    .pend  (mac_pend)
  );

  assign e_idx   = 4'({ctl.i, 1'b0}) + 4'(ctl.i) + 4'(ctl.j);
  assign a_idx   = 4'({ctl.i, 1'b0}) + 4'(ctl.i) + 4'(ctl.k);
  assign b_idx   = 4'({ctl.k, 1'b0}) + 4'(ctl.k) + 4'(ctl.j);
  assign sel     = elem_sel(e_idx);
  assign rnd_val = rnd_word(acc);

  always_comb begin
    case (ctl.i)
      2'd0:    scale_sel = item_r.scale_x;
      2'd1:    scale_sel = item_r.scale_y;
      default: scale_sel = item_r.scale_z;
    endcase
    case (ctl.j)
      2'd0:    trans_sel = item_r.trans_x;
      2'd1:    trans_sel = item_r.trans_y;
      default: trans_sel = item_r.trans_z;
    endcase
  end

  // Operand select for the shared multiplier
  always_comb begin
    req        = '0;
    req.mul_en = ctl.issue;
    if (ctl.loc) begin
      case (ctl.k)
        2'd0: begin
          req.a     = quat_pick(item_r, sel.a);
          req.b     = quat_pick(item_r, sel.b);
          req.dbl   = 1'b1;
          req.neg   = sel.neg_a;
          req.first = 1'b1;
          req.diag  = sel.diag;
        end
        2'd1: begin
          req.a   = quat_pick(item_r, sel.c);
          req.b   = quat_pick(item_r, sel.d);
          req.dbl = 1'b1;
          req.neg = sel.neg_c;
        end
        default: begin
          req.a     = coef_r;
          req.b     = scale_sel;
          req.first = 1'b1;
        end
      endcase
    end else begin
      req.a     = accum_r[a_idx];
      req.b     = l_r[b_idx];
      req.first = (ctl.k == 2'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      item_r <= in_data;
    end
    if (ctl.rnd) begin
      if (ctl.loc) begin
        if (ctl.k == 2'd1) begin
          coef_r <= rnd_val;
        end else begin
          l_r[e_idx] <= rnd_val;
        end
      end else if (ctl.i == 2'd3) begin
        t_r[e_idx] <= sat_add(rnd_val, trans_sel);
      end else begin
        t_r[e_idx] <= rnd_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int n = 0; n < N_ENT; n++) begin
        accum_r[n] <= '0;
      end
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.commit) begin
        if (item_r.chain_start) begin
          for (int n = 0; n < N_LOC; n++) begin
            accum_r[n] <= l_r[n];
          end
          accum_r[9]  <= item_r.trans_x;
          accum_r[10] <= item_r.trans_y;
          accum_r[11] <= item_r.trans_z;
        end else begin
          for (int n = 0; n < N_ENT; n++) begin
            accum_r[n] <= t_r[n];
          end
        end
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // accum_r only changes on commit, which waits for the output slot: hold it as payload
  assign out_valid    = out_valid_r;
  assign out_data.e00 = accum_r[0];
  assign out_data.e01 = accum_r[1];
  assign out_data.e02 = accum_r[2];
  assign out_data.e10 = accum_r[3];
  assign out_data.e11 = accum_r[4];
  assign out_data.e12 = accum_r[5];
  assign out_data.e20 = accum_r[6];
  assign out_data.e21 = accum_r[7];
  assign out_data.e22 = accum_r[8];
  assign out_data.e30 = accum_r[9];
  assign out_data.e31 = accum_r[10];
  assign out_data.e32 = accum_r[11];

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> !in_ready)
    else $error("in_ready high right after a node was accepted");

  a_round_settled: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.rnd |-> !mac_pend)
    else $error("rounding while a product is still being accumulated");

  a_commit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.commit |-> (!out_valid_r || out_ready))
    else $error("matrix committed over an unaccepted result");

  a_no_issue_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.idle |-> !req.mul_en && !ctl.rnd)
    else $error("multiplier used while idle");
`endif

endmodule

/* hdl/trs_mac.sv */
module trs_mac (
  input  logic              clk,
  input  logic              rst_n,
  input  trs_pkg::mac_req_t req,
  output trs_pkg::acc_t     acc,
  output logic              pend
);
  import trs_pkg::*;

  localparam acc_t ONE_SQ = acc_t'(1) << (2 * FRAC_W);

  logic signed [PROD_W-1:0] prod_r;
  logic                     pv_r;
  logic                     dbl_r;
  logic                     neg_r;
  logic                     first_r;
  logic                     diag_r;
  acc_t                     acc_r;
  acc_t                     acc_nxt;
  acc_t                     p_ext;
  acc_t                     term;
  acc_t                     base;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= req.mul_en;
    end
  end

  always_ff @(posedge clk) begin
    if (req.mul_en) begin
      prod_r  <= PROD_W'(req.a) * PROD_W'(req.b);
      dbl_r   <= req.dbl;
      neg_r   <= req.neg;
      first_r <= req.first;
      diag_r  <= req.diag;
    end
    if (pv_r) begin
      acc_r <= acc_nxt;
    end
  end

  always_comb begin
    p_ext = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
    term  = dbl_r ? (p_ext <<< 1) : p_ext;
    if (neg_r) begin
      term = -term;
    end
    if (first_r) begin
      base = diag_r ? ONE_SQ : '0;
    end else begin
      base = acc_r;
    end
    acc_nxt = base + term;
  end

  assign acc  = acc_r;
  assign pend = pv_r;

endmodule

/* hdl/trs_seq.sv */
module trs_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              chain_start,
  input  logic              slot_free,
  output trs_pkg::seq_ctl_t ctl
);
  import trs_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ISSUE = 5'b00010,
    S_WAIT  = 5'b00100,
    S_RND   = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] i_r, i_nxt;
  logic [1:0] j_r, j_nxt;
  logic [1:0] k_r, k_nxt;
  logic       loc_r, loc_nxt;
  logic       chain_r, chain_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
      loc_r   <= 1'b0;
      chain_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
      loc_r   <= loc_nxt;
      chain_r <= chain_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    loc_nxt   = loc_r;
    chain_nxt = chain_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_ISSUE;
          i_nxt     = '0;
          j_nxt     = '0;
          k_nxt     = '0;
          loc_nxt   = 1'b1;
          chain_nxt = chain_start;
        end
      end
      S_ISSUE: begin
        // local terms: ab then cd back to back, the scale term alone
        if (loc_r) begin
          if (k_r == 2'd0) begin
            k_nxt = 2'd1;
          end else begin
            state_nxt = S_WAIT;
          end
        end else begin
          if (k_r == 2'd2) begin
            state_nxt = S_WAIT;
          end else begin
            k_nxt = k_r + 2'd1;
          end
        end
      end
      S_WAIT: begin
        state_nxt = S_RND;
      end
      S_RND: begin
        if (loc_r && k_r == 2'd1) begin
          k_nxt     = 2'd2;
          state_nxt = S_ISSUE;
        end else begin
          k_nxt     = '0;
          state_nxt = S_ISSUE;
          if (loc_r && i_r == 2'd2 && j_r == 2'd2) begin
            i_nxt = '0;
            j_nxt = '0;
            if (chain_r) begin
              state_nxt = S_DONE;
            end else begin
              loc_nxt = 1'b0;
            end
          end else if (!loc_r && i_r == 2'd3 && j_r == 2'd2) begin
            state_nxt = S_DONE;
          end else if (j_r == 2'd2) begin
            j_nxt = '0;
            i_nxt = i_r + 2'd1;
          end else begin
            j_nxt = j_r + 2'd1;
          end
        end
      end
      S_DONE: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    ctl        = '0;
    ctl.idle   = (state_r == S_IDLE);
    ctl.issue  = (state_r == S_ISSUE);
    ctl.rnd    = (state_r == S_RND);
    ctl.commit = (state_r == S_DONE) && slot_free;
    ctl.loc    = loc_r;
    ctl.i      = i_r;
    ctl.j      = j_r;
    ctl.k      = k_r;
  end

endmodule

/* verif/tb_trs_node_world_transform_core.sv */
module tb_trs_node_world_transform_core;
  timeunit 1ns;
  timeprecision 1ps;

  import trs_pkg::*;

  localparam int RAND_ITEMS   = 1780;
  localparam int TAIL_ITEMS   = 150;
  localparam int STALL_LIMIT  = 4000;
  localparam int SETTLE_CYCLES = 200;

  typedef logic signed [127:0] wide_t;

  localparam wide_t WIDE_MAX = {1'b0, {127{1'b1}}};
  localparam wide_t WIDE_MIN = {1'b1, {127{1'b0}}};
  localparam wide_t WORD_TOP = 128'sh7fff_ffff;
  localparam wide_t WORD_BOT = -128'sh8000_0000;
  localparam wide_t HALF_LSB = 128'sd1 <<< (FRAC_W - 1);
  localparam wide_t UNIT_Q2  = 128'sd1 <<< (2 * FRAC_W);

  localparam word_t W_MAX   = 32'sh7fff_ffff;
  localparam word_t W_MIN   = 32'sh8000_0000;
  localparam word_t ONE_Q   = 32'sh0001_0000;
  localparam word_t HALF_Q  = 32'sh0000_8000;
  localparam word_t COS45_Q = 32'sh0000_b505;

  typedef enum logic [2:0] {
    VAL_FULL,
    VAL_UNIT,
    VAL_SCALE,
    VAL_TRANS,
    VAL_CORNER
  } val_kind_t;

  typedef struct {
    in_item_t node;
    bit       drain_first;
  } pend_node_t;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  pend_node_t pending_nodes[$];
  out_item_t  expected_mats[$];
  word_t      world_mat[N_ENT];

  bit          in_taken;
  bit          tail_calm;
  int unsigned in_gap;
  int unsigned out_stall;
  int unsigned cycle_cnt;
  int unsigned quiet_cycles;
  int unsigned err_count;
  out_item_t   exp_mat;
  int          bad_fields;
  int          first_bad;
  bit          idle_ok;
  logic        nxt_valid;

  trs_node_world_transform_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Saturating arithmetic at 128 bits.
  function automatic wide_t add_wide(input wide_t a, input wide_t b);
    wide_t s;
    s = a + b;
    if (a[127] == b[127] && s[127] != a[127]) begin
      s = a[127] ? WIDE_MIN : WIDE_MAX;
    end
    return s;
  endfunction

  function automatic wide_t neg_wide(input wide_t a);
    if (a == WIDE_MIN) begin
      return WIDE_MAX;
    end
    return -a;
  endfunction

  function automatic wide_t mul_wide(input word_t a, input word_t b);
    wide_t wa;
    wide_t wb;
    wa = a;
    wb = b;
    return wa * wb;
  endfunction

  // Round half up from 2*FRAC_W fraction bits, clamp to a word.
  function automatic word_t round_word(input wide_t v);
    wide_t s;
    s = add_wide(v, HALF_LSB);
    s = s >>> FRAC_W;
    if (s > WORD_TOP) begin
      return W_MAX;
    end else if (s < WORD_BOT) begin
      return W_MIN;
    end
    return s[WORD_W-1:0];
  endfunction

  function automatic word_t add_word(input word_t a, input word_t b);
    logic signed [WORD_W:0] s;
    s = (WORD_W+1)'(a) + (WORD_W+1)'(b);
    if (s[WORD_W] != s[WORD_W-1]) begin
      return s[WORD_W] ? W_MIN : W_MAX;
    end
    return s[WORD_W-1:0];
  endfunction

  function automatic wide_t twice_prod(input word_t a, input word_t b, input bit neg);
    wide_t p;
    p = mul_wide(a, b);
    p = add_wide(p, p);
    return neg ? neg_wide(p) : p;
  endfunction

  // (diag ? 1 : 0) +- 2ab +- 2cd, rounded, then scaled and rounded again
  function automatic word_t rot_coef(input bit diag, input word_t a, input word_t b,
                                     input bit na, input word_t c, input word_t d,
                                     input bit nc, input word_t s);
    wide_t acc;
    word_t coef;
    acc = diag ? UNIT_Q2 : '0;
    acc = add_wide(acc, twice_prod(a, b, na));
    acc = add_wide(acc, twice_prod(c, d, nc));
    coef = round_word(acc);
    return round_word(mul_wide(coef, s));
  endfunction

  // Fold one node into the accumulated matrix and return the twelve entries.
  function automatic out_item_t compose_node(input in_item_t n);
    word_t     q[4];
    word_t     loc[N_ENT];
    word_t     nxt[N_ENT];
    wide_t     acc;
    out_item_t r;
    q[Q_X] = n.quat_x;
    q[Q_Y] = n.quat_y;
    q[Q_Z] = n.quat_z;
    q[Q_W] = n.quat_w;
    loc[0]  = rot_coef(1'b1, q[Q_Y], q[Q_Y], 1'b1, q[Q_Z], q[Q_Z], 1'b1, n.scale_x);
    loc[1]  = rot_coef(1'b0, q[Q_X], q[Q_Y], 1'b0, q[Q_Z], q[Q_W], 1'b0, n.scale_x);
    loc[2]  = rot_coef(1'b0, q[Q_X], q[Q_Z], 1'b0, q[Q_Y], q[Q_W], 1'b1, n.scale_x);
    loc[3]  = rot_coef(1'b0, q[Q_X], q[Q_Y], 1'b0, q[Q_Z], q[Q_W], 1'b1, n.scale_y);
    loc[4]  = rot_coef(1'b1, q[Q_X], q[Q_X], 1'b1, q[Q_Z], q[Q_Z], 1'b1, n.scale_y);
    loc[5]  = rot_coef(1'b0, q[Q_Y], q[Q_Z], 1'b0, q[Q_X], q[Q_W], 1'b0, n.scale_y);
    loc[6]  = rot_coef(1'b0, q[Q_X], q[Q_Z], 1'b0, q[Q_Y], q[Q_W], 1'b0, n.scale_z);
    loc[7]  = rot_coef(1'b0, q[Q_Y], q[Q_Z], 1'b0, q[Q_X], q[Q_W], 1'b1, n.scale_z);
    loc[8]  = rot_coef(1'b1, q[Q_X], q[Q_X], 1'b1, q[Q_Y], q[Q_Y], 1'b1, n.scale_z);
    loc[9]  = n.trans_x;
    loc[10] = n.trans_y;
    loc[11] = n.trans_z;
    if (n.chain_start) begin
      world_mat = loc;
    end else begin
      // every row, translation included, goes through the ancestor's 3x3 part
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 3; j++) begin
          acc = '0;
          for (int k = 0; k < 3; k++) begin
            acc = add_wide(acc, mul_wide(world_mat[i*3+k], loc[k*3+j]));
          end
          nxt[i*3+j] = round_word(acc);
        end
      end
      for (int j = 0; j < 3; j++) begin
        nxt[9+j] = add_word(nxt[9+j], loc[9+j]);
      end
      world_mat = nxt;
    end
    for (int f = 0; f < N_ENT; f++) begin
      r[(N_ENT-1-f)*WORD_W +: WORD_W] = world_mat[f];
    end
    return r;
  endfunction

  function automatic in_item_t make_node(input word_t tx, input word_t ty, input word_t tz,
                                         input word_t qx, input word_t qy, input word_t qz,
                                         input word_t qw, input word_t sx, input word_t sy,
                                         input word_t sz, input bit start);
    in_item_t n;
    n.trans_x     = tx;
    n.trans_y     = ty;
    n.trans_z     = tz;
    n.quat_x      = qx;
    n.quat_y      = qy;
    n.quat_z      = qz;
    n.quat_w      = qw;
    n.scale_x     = sx;
    n.scale_y     = sy;
    n.scale_z     = sz;
    n.chain_start = start;
    return n;
  endfunction

  function automatic word_t draw_val(input val_kind_t kind);
    word_t v;
    case (kind)
      VAL_UNIT:  v = word_t'(int'($urandom_range(0, 131072)) - 65536);
      VAL_SCALE: v = word_t'(int'($urandom_range(0, 524288)) - 262144);
      VAL_TRANS: v = word_t'(int'($urandom_range(0, 33554432)) - 16777216);
      VAL_CORNER: begin
        case ($urandom_range(0, 7))
          0:       v = W_MAX;
          1:       v = W_MIN;
          2:       v = '0;
          3:       v = -32'sd1;
          4:       v = 32'sd1;
          5:       v = ONE_Q;
          6:       v = -ONE_Q;
          default: v = HALF_Q;
        endcase
      end
      default:   v = $urandom;
    endcase
    return v;
  endfunction

  function automatic val_kind_t pick_kind(input int profile, input val_kind_t usual);
    if (profile < 13) begin
      return usual;
    end else if (profile < 16) begin
      return VAL_FULL;
    end
    return val_kind_t'($urandom_range(0, 4));
  endfunction

  function automatic in_item_t draw_node(input bit start);
    int p;
    p = $urandom_range(0, 19);
    return make_node(draw_val(pick_kind(p, VAL_TRANS)), draw_val(pick_kind(p, VAL_TRANS)),
                     draw_val(pick_kind(p, VAL_TRANS)), draw_val(pick_kind(p, VAL_UNIT)),
                     draw_val(pick_kind(p, VAL_UNIT)), draw_val(pick_kind(p, VAL_UNIT)),
                     draw_val(pick_kind(p, VAL_UNIT)), draw_val(pick_kind(p, VAL_SCALE)),
                     draw_val(pick_kind(p, VAL_SCALE)), draw_val(pick_kind(p, VAL_SCALE)),
                     start);
  endfunction

  task automatic queue_node(input in_item_t n, input bit drain);
    pend_node_t e;
    e.node        = n;
    e.drain_first = drain;
    pending_nodes.push_back(e);
  endtask

  // Sender: hold the transaction until taken, then idle or present the next node.
  always @(negedge clk) begin
    idle_ok = !tail_calm && (cycle_cnt[10:9] != 2'b11);
    if (rst_n) begin
      if (pending_nodes.size() <= TAIL_ITEMS) begin
        tail_calm = 1'b1;
      end
      nxt_valid = in_valid && !in_taken;
      if (in_valid && in_taken && idle_ok && $urandom_range(0, 2) == 0) begin
        in_gap = $urandom_range(1, 9);
      end
      if (!nxt_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_nodes.size() > 0 &&
                     (!pending_nodes[0].drain_first || expected_mats.size() == 0)) begin
          in_data <= pending_nodes[0].node;
          pending_nodes.pop_front();
          nxt_valid = 1'b1;
        end
      end
      in_valid <= nxt_valid;

      if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else if (idle_ok && $urandom_range(0, 15) == 0) begin
        out_stall = $urandom_range(0, 8);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Predict on every accepted node, check every accepted result, watch for hangs.
  always @(posedge clk) begin
    cycle_cnt++;
    in_taken = 1'b0;
    if (rst_n) begin
      in_taken = in_valid && in_ready;
      if (in_taken) begin
        expected_mats.push_back(compose_node(in_data));
      end
      if (out_valid && out_ready) begin
        if (expected_mats.size() == 0) begin
          err_count++;
          if (err_count <= 10) begin
            $display("unexpected result transaction: %h", out_data);
          end
        end else begin
          exp_mat = expected_mats.pop_front();
          bad_fields = 0;
          first_bad = -1;
          for (int f = 0; f < N_ENT; f++) begin
            if (exp_mat[(N_ENT-1-f)*WORD_W +: WORD_W] !== out_data[(N_ENT-1-f)*WORD_W +: WORD_W])
            begin
              bad_fields++;
              if (first_bad < 0) begin
                first_bad = f;
              end
            end
          end
          if (bad_fields > 0) begin
            err_count++;
            if (err_count <= 10) begin
              $display("mismatch in e%0d%0d (%0d entries differ): expected %h got %h",
                       first_bad / 3, first_bad % 3, bad_fields,
                       exp_mat[(N_ENT-1-first_bad)*WORD_W +: WORD_W],
                       out_data[(N_ENT-1-first_bad)*WORD_W +: WORD_W]);
            end
          end
        end
      end
      if (in_taken || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("trs_node_world_transform_core regression: fail");
        $finish;
      end
    end
  end

  initial begin
    int n_rand;
    int chain_len;
    bit start;
    for (int f = 0; f < N_ENT; f++) begin
      world_mat[f] = '0;
    end

    // Ancestors ahead of any chain start see the zero matrix from reset.
    queue_node(make_node(5 * ONE_Q, -3 * ONE_Q, 7 * ONE_Q + HALF_Q, '0, '0, '0, ONE_Q,
                         ONE_Q, ONE_Q, ONE_Q, 1'b0), 1'b0);
    queue_node(make_node(W_MAX, W_MIN, W_MAX, COS45_Q, '0, '0, COS45_Q,
                         ONE_Q, 2 * ONE_Q, HALF_Q, 1'b0), 1'b0);
    // identity start, then a quarter turn about z
    queue_node(make_node('0, '0, '0, '0, '0, '0, ONE_Q, ONE_Q, ONE_Q, ONE_Q, 1'b1), 1'b0);
    queue_node(make_node(ONE_Q, 2 * ONE_Q, 3 * ONE_Q, '0, '0, COS45_Q, COS45_Q,
                         ONE_Q, ONE_Q, ONE_Q, 1'b0), 1'b0);
    // field extremes
    queue_node(make_node(W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX,
                         W_MAX, W_MAX, W_MAX, 1'b1), 1'b0);
    queue_node(make_node(W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX,
                         W_MAX, W_MAX, W_MAX, 1'b0), 1'b0);
    queue_node(make_node(W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN,
                         W_MIN, W_MIN, W_MIN, 1'b1), 1'b0);
    queue_node(make_node(W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN,
                         W_MIN, W_MIN, W_MIN, 1'b0), 1'b0);
    queue_node(make_node('0, '0, '0, '0, '0, '0, '0, '0, '0, '0, 1'b1), 1'b0);
    queue_node(make_node(-32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1,
                         -32'sd1, -32'sd1, -32'sd1, 1'b0), 1'b0);
    // huge, unnormalized quaternion
    queue_node(make_node(ONE_Q, ONE_Q, ONE_Q, 100 * ONE_Q, 100 * ONE_Q, 100 * ONE_Q,
                         100 * ONE_Q, ONE_Q, ONE_Q, ONE_Q, 1'b1), 1'b0);
    // translation sums that clamp high, then low
    queue_node(make_node(W_MAX, W_MAX, W_MAX, '0, '0, '0, ONE_Q,
                         ONE_Q, ONE_Q, ONE_Q, 1'b1), 1'b0);
    queue_node(make_node(W_MAX, W_MAX, W_MAX, '0, '0, '0, ONE_Q,
                         ONE_Q, ONE_Q, ONE_Q, 1'b0), 1'b0);
    queue_node(make_node(W_MIN, W_MIN, W_MIN, '0, '0, '0, ONE_Q,
                         ONE_Q, ONE_Q, ONE_Q, 1'b1), 1'b0);
    queue_node(make_node(W_MIN, W_MIN, W_MIN, '0, '0, '0, ONE_Q,
                         ONE_Q, ONE_Q, ONE_Q, 1'b0), 1'b0);
    // zero quaternion keeps only the diagonal
    queue_node(make_node(ONE_Q, -ONE_Q, HALF_Q, '0, '0, '0, '0,
                         2 * ONE_Q, -3 * ONE_Q, HALF_Q, 1'b1), 1'b0);
    queue_node(make_node(-ONE_Q, ONE_Q, '0, W_MIN, W_MAX, W_MIN, W_MAX,
                         W_MAX, W_MIN, ONE_Q, 1'b0), 1'b0);

    // Mostly well-formed chains; occasional stray chain_start values as noise.
    n_rand = 0;
    while (n_rand < RAND_ITEMS) begin
      queue_node(draw_node(1'b1), n_rand == 0 || $urandom_range(0, 199) == 0);
      n_rand++;
      chain_len = $urandom_range(0, 5);
      for (int a = 0; a < chain_len && n_rand < RAND_ITEMS; a++) begin
        start = ($urandom_range(0, 9) == 0) ? 1'($urandom_range(0, 1)) : 1'b0;
        queue_node(draw_node(start), 1'b0);
        n_rand++;
      end
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_nodes.size() != 0 || in_valid || expected_mats.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (err_count == 0 && expected_mats.size() == 0) begin
      $display("trs_node_world_transform_core regression: pass");
    end else begin
      $display("trs_node_world_transform_core regression: fail");
    end
    $finish;
  end

endmodule
